// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Checks that the consequent follows the antecedent.
`define ASSERT_AFTER2(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg)
`define ASSERT_AFTER2(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/i3t_pkg.sv =====
package i3t_pkg;

	// Encoding codes carried on the first item of a frame.
	localparam logic [7:0] ENC_LATIN1    = 8'd0;
	localparam logic [7:0] ENC_UTF16_BOM = 8'd1;
	localparam logic [7:0] ENC_UTF16BE   = 8'd2;

	// Byte-order mark bytes.
	localparam logic [7:0] BOM_FE = 8'hFE;
	localparam logic [7:0] BOM_FF = 8'hFF;

	// Top six bits of high and low surrogates.
	localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
	localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

	// First plane above the basic multilingual plane.
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	// Capacity after reset.
	localparam logic [15:0] CAP_RESET = 16'd512;

	typedef enum logic [1:0] {
		MODE_LATIN1 = 2'd0,
		MODE_UTF16  = 2'd1,
		MODE_COPY   = 2'd2
	} mode_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic [7:0] text_encoding;
		logic       first_of_frame;
		logic       last_of_frame;
	} in_item_t;

	typedef struct packed {
		logic [7:0] utf8_byte;
		logic       end_of_string;
	} result_t;

	// Work for the back end: up to two code points and a terminator.
	// A length of zero marks an unused slot; length one emits the low byte as is.
	typedef struct packed {
		logic [20:0] cp0;
		logic [2:0]  len0;
		logic [20:0] cp1;
		logic [2:0]  len1;
		logic        term;
	} cmd_t;

	// Number of UTF-8 bytes needed for a code point.
	function automatic logic [2:0] utf8_len(input logic [20:0] cp);
		logic [2:0] n;
		if (cp < 21'h80) begin
			n = 3'd1;
		end else if (cp < 21'h800) begin
			n = 3'd2;
		end else if (cp < SUPP_BASE) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	// One byte of the UTF-8 form of a code point of the given length.
	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
			input logic [1:0] idx);
		logic [7:0] b;
		unique case (len)
			3'd1: b = cp[7:0];
			3'd2: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			3'd3: begin
				unique case (idx)
					2'd0: b = {4'b1110, cp[15:12]};
					2'd1: b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			3'd4: begin
				unique case (idx)
					2'd0: b = {5'b11110, cp[20:18]};
					2'd1: b = {2'b10, cp[17:12]};
					2'd2: b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== sv/i3t_front.sv =====
module i3t_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  i3t_pkg::in_item_t item,
	input  logic [15:0]       capacity,
	output i3t_pkg::cmd_t     cmd,
	output logic              has_output
);

	// Decoder state.
	i3t_pkg::mode_t mode_q;
	logic        big_q;
	logic        phase_q;
	logic [7:0]  held_low_q;
	logic [9:0]  held_hs_q;
	logic        pend_q;
	logic        bom_q;
	logic [15:0] bw_q;
	logic        stopped_q;

	i3t_pkg::mode_t mode_n;
	logic        big_n;
	logic        phase_n;
	logic [7:0]  held_low_n;
	logic [9:0]  held_hs_n;
	logic        pend_n;
	logic        bom_n;
	logic [15:0] bw_n;
	logic        stopped_n;

	// Classify the item and work out the code points it releases.
	always_comb begin
		i3t_pkg::mode_t e_mode;
		logic        e_big;
		logic        e_phase;
		logic        e_pend;
		logic        e_bom;
		logic [15:0] e_bw;
		logic        e_stopped;
		logic        bom_hit;
		logic        pair_done;
		logic [15:0] unit;
		logic [15:0] bw_mid;
		logic [7:0]  b;
		i3t_pkg::cmd_t c;

		b         = item.data_byte;
		e_mode    = mode_q;
		e_big     = big_q;
		e_phase   = phase_q;
		e_pend    = pend_q;
		e_bom     = bom_q;
		e_bw      = bw_q;
		e_stopped = stopped_q;
		held_low_n = held_low_q;
		held_hs_n  = held_hs_q;
		phase_n    = phase_q;
		bom_hit    = 1'b0;
		pair_done  = 1'b0;
		unit       = 16'h0000;
		bw_mid     = 16'h0000;
		c          = '0;

		// A frame start restarts the decoder and picks the mode.
		if (item.first_of_frame) begin
			e_pend     = 1'b0;
			e_bw       = 16'h0000;
			e_stopped  = 1'b0;
			e_phase    = 1'b0;
			held_low_n = 8'h00;
			held_hs_n  = 10'h000;
			phase_n    = 1'b0;
			e_big      = (item.text_encoding == i3t_pkg::ENC_UTF16BE);
			e_bom      = (item.text_encoding == i3t_pkg::ENC_UTF16BE);
			if (item.text_encoding == i3t_pkg::ENC_LATIN1) begin
				e_mode = i3t_pkg::MODE_LATIN1;
			end else if (item.text_encoding == i3t_pkg::ENC_UTF16_BOM ||
					item.text_encoding == i3t_pkg::ENC_UTF16BE) begin
				e_mode = i3t_pkg::MODE_UTF16;
			end else begin
				e_mode = i3t_pkg::MODE_COPY;
			end
		end

		mode_n    = e_mode;
		big_n     = e_big;
		pend_n    = e_pend;
		bom_n     = e_bom;
		stopped_n = e_stopped;

		// Take the byte unless output has already stopped.
		if (item.byte_valid && !e_stopped) begin
			unique case (e_mode)
				i3t_pkg::MODE_LATIN1: begin
					if (({2'b00, e_bw} + 18'd2 >= {2'b00, capacity}) || b == 8'h00) begin
						stopped_n = 1'b1;
					end else begin
						c.cp0  = {13'h0000, b};
						c.len0 = i3t_pkg::utf8_len({13'h0000, b});
					end
				end
				i3t_pkg::MODE_UTF16: begin
					if (!e_phase) begin
						held_low_n = b;
						phase_n    = 1'b1;
					end else begin
						phase_n = 1'b0;
						// The first unit of a frame may be a byte-order mark.
						if (!e_bom) begin
							bom_n = 1'b1;
							if (held_low_q == i3t_pkg::BOM_FE && b == i3t_pkg::BOM_FF) begin
								big_n   = 1'b1;
								bom_hit = 1'b1;
							end else if (held_low_q == i3t_pkg::BOM_FF &&
									b == i3t_pkg::BOM_FE) begin
								big_n   = 1'b0;
								bom_hit = 1'b1;
							end
						end
						if (!bom_hit) begin
							unit   = e_big ? {held_low_q, b} : {b, held_low_q};
							bw_mid = e_bw;
							// A held high surrogate pairs up or goes out alone.
							if (e_pend) begin
								pend_n = 1'b0;
								if (unit[15:10] == i3t_pkg::LOW_SURR_TAG) begin
									c.cp0     = i3t_pkg::SUPP_BASE +
										{1'b0, held_hs_q, unit[9:0]};
									c.len0    = 3'd4;
									pair_done = 1'b1;
								end else begin
									c.cp0  = {5'h00, i3t_pkg::HIGH_SURR_TAG, held_hs_q};
									c.len0 = 3'd3;
									bw_mid = e_bw + 16'd3;
								end
							end
							if (!pair_done) begin
								if (({2'b00, bw_mid} + 18'd4 >= {2'b00, capacity}) ||
										unit == 16'h0000) begin
									stopped_n = 1'b1;
								end else if (unit[15:10] == i3t_pkg::HIGH_SURR_TAG) begin
									held_hs_n = unit[9:0];
									pend_n    = 1'b1;
								end else begin
									c.cp1  = {5'h00, unit};
									c.len1 = i3t_pkg::utf8_len({5'h00, unit});
								end
							end
						end
					end
				end
				default: begin
					if (({2'b00, e_bw} + 18'd1 >= {2'b00, capacity}) || b == 8'h00) begin
						stopped_n = 1'b1;
					end else begin
						c.cp0  = {13'h0000, b};
						c.len0 = 3'd1;
					end
				end
			endcase
		end

		// Frame end flushes a held high surrogate and adds the terminator.
		if (item.last_of_frame) begin
			if (pend_n) begin
				pend_n = 1'b0;
				c.cp1  = {5'h00, i3t_pkg::HIGH_SURR_TAG, held_hs_n};
				c.len1 = 3'd3;
			end
			c.term    = 1'b1;
			stopped_n = 1'b1;
			phase_n   = 1'b0;
		end

		bw_n       = e_bw + {13'h0000, c.len0} + {13'h0000, c.len1};
		cmd        = c;
		has_output = (c.len0 != 3'd0) || (c.len1 != 3'd0) || c.term;
	end

	// State moves on each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= i3t_pkg::MODE_LATIN1;
			big_q      <= 1'b0;
			phase_q    <= 1'b0;
			held_low_q <= 8'h00;
			held_hs_q  <= 10'h000;
			pend_q     <= 1'b0;
			bom_q      <= 1'b0;
			bw_q       <= 16'h0000;
			stopped_q  <= 1'b0;
		end else if (accept) begin
			mode_q     <= mode_n;
			big_q      <= big_n;
			phase_q    <= phase_n;
			held_low_q <= held_low_n;
			held_hs_q  <= held_hs_n;
			pend_q     <= pend_n;
			bom_q      <= bom_n;
			bw_q       <= bw_n;
			stopped_q  <= stopped_n;
		end
	end

endmodule

// ===== sv/i3t_cmd_queue.sv =====
module i3t_cmd_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  i3t_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output i3t_pkg::cmd_t rd_data,
	output logic          not_empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	i3t_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	// Storage entries.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers wrap at the last entry and the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/i3t_back.sv =====
module i3t_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  i3t_pkg::cmd_t    cmd,
	output logic             cmd_take,
	output i3t_pkg::result_t result,
	output logic             empty,
	input  logic             pop
);

	// Working copy of the command being serialized.
	logic [20:0] cp0_q;
	logic [2:0]  len0_q;
	logic [20:0] cp1_q;
	logic [2:0]  len1_q;
	logic        term_q;
	logic [1:0]  idx_q;

	logic             out_valid_q;
	i3t_pkg::result_t out_q;

	logic        busy;
	logic        step;
	logic        last_step;
	logic [2:0]  len0_n;
	logic [2:0]  len1_n;
	logic        term_n;
	logic [1:0]  idx_n;
	i3t_pkg::result_t byte_n;

	assign busy = (len0_q != 3'd0) || (len1_q != 3'd0) || term_q;
	assign step = busy && (!out_valid_q || pop);

	// Pick the next byte: first slot, then second slot, then the terminator.
	always_comb begin
		len0_n = len0_q;
		len1_n = len1_q;
		term_n = term_q;
		idx_n  = idx_q;
		byte_n = '0;
		priority if (len0_q != 3'd0) begin
			byte_n.utf8_byte = i3t_pkg::utf8_byte(cp0_q, len0_q, idx_q);
			if ({1'b0, idx_q} == len0_q - 3'd1) begin
				len0_n = 3'd0;
				idx_n  = 2'd0;
			end else begin
				idx_n = idx_q + 2'd1;
			end
		end else if (len1_q != 3'd0) begin
			byte_n.utf8_byte = i3t_pkg::utf8_byte(cp1_q, len1_q, idx_q);
			if ({1'b0, idx_q} == len1_q - 3'd1) begin
				len1_n = 3'd0;
				idx_n  = 2'd0;
			end else begin
				idx_n = idx_q + 2'd1;
			end
		end else begin
			byte_n.end_of_string = 1'b1;
			term_n               = 1'b0;
		end
	end

	assign last_step = step && (len0_n == 3'd0) && (len1_n == 3'd0) && !term_n;
	assign cmd_take  = cmd_valid && (!busy || last_step);

	// Command payload needs no reset.
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cp0_q <= cmd.cp0;
			cp1_q <= cmd.cp1;
		end
		if (step) begin
			out_q <= byte_n;
		end
	end

	// Slot lengths, byte index and the output register's valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len0_q      <= 3'd0;
			len1_q      <= 3'd0;
			term_q      <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				len0_q <= cmd.len0;
				len1_q <= cmd.len1;
				term_q <= cmd.term;
				idx_q  <= 2'd0;
			end else if (step) begin
				len0_q <= len0_n;
				len1_q <= len1_n;
				term_q <= term_n;
				idx_q  <= idx_n;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result = out_q;
	assign empty  = !out_valid_q;

endmodule

// ===== sv/id3_text_to_utf8_transcoder.sv =====
// Path: with the back end idle, a taken transaction is written into the command queue, then
// loaded into the back end's working copy; its first byte then goes to the output register.
// Throughput: one result byte per cycle while results are popped; a transaction releases up
// to seven bytes (two code points and the terminator), so output bytes set the pace. Input
// takes one transaction per cycle while the command queue has room.
// Reset: arst_n clears control state, not data, and loads the capacity register with 512.
`include "assert_macros.svh"

module id3_text_to_utf8_transcoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  i3t_pkg::in_item_t in_item,
	output logic              empty,
	input  logic              pop,
	output i3t_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata
);

	logic [15:0]   capacity_q;
	logic          accept;
	logic          q_push;
	logic          has_output;
	i3t_pkg::cmd_t front_cmd;
	logic          q_not_empty;
	logic          q_pop;
	i3t_pkg::cmd_t q_head;

	// Output capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= i3t_pkg::CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	assign accept = push && !full;
	assign q_push = accept && has_output;

	// Front end decodes each transaction into a command.
	i3t_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (in_item),
		.capacity   (capacity_q),
		.cmd        (front_cmd),
		.has_output (has_output)
	);

	// Commands wait here between the two halves.
	i3t_cmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (q_push),
		.wr_data   (front_cmd),
		.full      (full),
		.rd_en     (q_pop),
		.rd_data   (q_head),
		.not_empty (q_not_empty)
	);

	// Back end turns commands into a byte stream.
	i3t_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_not_empty),
		.cmd       (q_head),
		.cmd_take  (q_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

	// Consistency checks between front end, queue and back end.
	`ASSERT_IMPLIES(a_last_makes_term, clk, arst_n, accept && in_item.last_of_frame,
		q_push && front_cmd.term, "frame end did not queue a terminator")
	`ASSERT_IMPLIES(a_cmd_len_range, clk, arst_n, q_push,
		front_cmd.len0 <= 3'd4 && front_cmd.len1 <= 3'd4, "command slot longer than four bytes")
	`ASSERT_IMPLIES(a_eos_is_zero, clk, arst_n, !empty && result.end_of_string,
		result.utf8_byte == 8'h00, "terminator carries a nonzero byte")
	`ASSERT_AFTER2(a_take_reaches_out, clk, arst_n, q_pop && empty, !empty,
		"taken command produced no result")

endmodule
